// ===== hw/rtl/multi_list_lru_with_expiry_recycle_top_assert.svh =====
// Assertion macros used by the checker file mlre_checker.sv.
`ifndef MULTI_LIST_LRU_WITH_EXPIRY_RECYCLE_TOP_ASSERT_SVH
`define MULTI_LIST_LRU_WITH_EXPIRY_RECYCLE_TOP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define MLRE_ASSERT_SAME(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define MLRE_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/mlre_pkg.sv =====
// ----------------------------------------------------------------------------
// mlre_pkg
// Shared types, codes and defaults for the segmented LRU list block.
// ----------------------------------------------------------------------------
`default_nettype none

package mlre_pkg;

  localparam int DEF_NUM_ENTRIES = 1024;
  localparam int DEF_NUM_CLASSES = 64;
  localparam int DEF_SCAN_DEPTH  = 3;

  localparam int ENTRY_W  = 10;
  localparam int CLASS_W  = 6;
  localparam int TIME_W   = 32;
  localparam int COUNT_W  = 11;
  localparam int CLASS_CODES = 1 << CLASS_W;

  typedef enum logic [1:0] {
    KIND_ADD     = 2'd0,
    KIND_REMOVE  = 2'd1,
    KIND_ACCESS  = 2'd2,
    KIND_RECYCLE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_UNLINKED = 2'd2,
    ST_LINKED   = 2'd3
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic    clr;
    logic    load;
    logic    cap_head;
    logic    cap_cnt;
    logic    cap_tail;
    logic    cap_cls;
    logic    scan;
    logic    unlink;
    logic    link;
    logic    link2;
    logic    finish;
    status_t fin_status;
  } mlre_cmd_t;

  // datapath -> controller
  typedef struct packed {
    kind_t kind;
    logic  e_valid;
    logic  linked;
    logic  tail_null;
    logic  scan_hit;
    logic  scan_stop;
    logic  clr_done;
  } mlre_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/multi_list_lru_with_expiry_recycle_top.sv =====
// ----------------------------------------------------------------------------
// multi_list_lru_with_expiry_recycle_top
// Segmented LRU lists with a bounded expiry scan on recycle.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a transaction is taken at a rising edge with start high
//   and busy low; kind, entry, list_class, expiry and now are sampled there.
//   Result channel: done pulses for one cycle with status, victim_entry,
//   victim_expired and list_count. The receiver cannot stall; the result is
//   gone after that cycle, so it must be captured when done is seen.
//   Steps from accept to done (done rises the cycle busy falls):
//     error answers            lookup
//     add                      lookup, link, second prev-table write
//     remove                   lookup, class read, count read, unlink
//     access                   as remove, then link, second prev-table write
//     recycle                  lookup, scan of 1..SCAN_DEPTH entries, unlink
//   One transaction at a time; the next may be accepted while done is high.
//   The steps come from the single-port pointer tables: every lookup
//   costs a registered read, and a link needs two writes to the prev table.
//   Reset: synchronous. After reset the block sweeps its tables over
//   max(NUM_ENTRIES, NUM_CLASSES) indices (1024 by default) with busy high,
//   clearing linked flags and list heads, tails and counts.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_list_lru_with_expiry_recycle_top import mlre_pkg::*; #(
  parameter int NUM_ENTRIES = DEF_NUM_ENTRIES,
  parameter int NUM_CLASSES = DEF_NUM_CLASSES,
  parameter int SCAN_DEPTH  = DEF_SCAN_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         kind,
  input  wire logic [ENTRY_W-1:0] entry,
  input  wire logic [CLASS_W-1:0] list_class,
  input  wire logic [TIME_W-1:0]  expiry,
  input  wire logic [TIME_W-1:0]  now,
  output logic                    done,
  output logic [1:0]              status,
  output logic [ENTRY_W-1:0]      victim_entry,
  output logic                    victim_expired,
  output logic [COUNT_W-1:0]      list_count
);

  // command and status between sequencer and datapath
  mlre_cmd_t  cmd;
  mlre_stat_t stat;

  mlre_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // tables, scan logic and result registers
  mlre_dp #(
    .NUM_ENTRIES (NUM_ENTRIES),
    .NUM_CLASSES (NUM_CLASSES),
    .SCAN_DEPTH  (SCAN_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .kind           (kind),
    .entry          (entry),
    .list_class     (list_class),
    .expiry         (expiry),
    .now            (now),
    .done           (done),
    .status         (status),
    .victim_entry   (victim_entry),
    .victim_expired (victim_expired),
    .list_count     (list_count)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/mlre_dp.sv =====
// ----------------------------------------------------------------------------
// mlre_dp
// Datapath: pointer tables, per-class head/tail/count, scan and result regs.
// ----------------------------------------------------------------------------
`default_nettype none

module mlre_dp import mlre_pkg::*; #(
  parameter int NUM_ENTRIES = DEF_NUM_ENTRIES,
  parameter int NUM_CLASSES = DEF_NUM_CLASSES,
  parameter int SCAN_DEPTH  = DEF_SCAN_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire mlre_cmd_t          cmd,
  output mlre_stat_t              stat,
  input  wire logic [1:0]         kind,
  input  wire logic [ENTRY_W-1:0] entry,
  input  wire logic [CLASS_W-1:0] list_class,
  input  wire logic [TIME_W-1:0]  expiry,
  input  wire logic [TIME_W-1:0]  now,
  output logic                    done,
  output logic [1:0]              status,
  output logic [ENTRY_W-1:0]      victim_entry,
  output logic                    victim_expired,
  output logic [COUNT_W-1:0]      list_count
);

  localparam int AW    = $clog2(NUM_ENTRIES);
  localparam int PW    = $clog2(NUM_ENTRIES + 1);
  localparam int CW    = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int NW    = (SCAN_DEPTH > 1) ? $clog2(SCAN_DEPTH) : 1;
  localparam int CLR_N = (NUM_ENTRIES > NUM_CLASSES) ? NUM_ENTRIES : NUM_CLASSES;
  localparam int RW    = $clog2(CLR_N);
  localparam logic [PW-1:0] NIL = PW'(NUM_ENTRIES);

  // class code reduced modulo the class count
  logic [CW-1:0] cmod_tab [CLASS_CODES];
  for (genvar g = 0; g < CLASS_CODES; g++) begin : g_cmod
    assign cmod_tab[g] = CW'(g % NUM_CLASSES);
  end

  // memories
  logic [PW-1:0]     nxt_mem  [NUM_ENTRIES];
  logic [PW-1:0]     prv_mem  [NUM_ENTRIES];
  logic [TIME_W-1:0] exp_mem  [NUM_ENTRIES];
  logic [CW-1:0]     cls_mem  [NUM_ENTRIES];
  logic              lnk_mem  [NUM_ENTRIES];
  logic [PW-1:0]     head_mem [NUM_CLASSES];
  logic [PW-1:0]     tail_mem [NUM_CLASSES];
  logic [PW-1:0]     cnt_mem  [NUM_CLASSES];

  logic [PW-1:0]     rd_nxt, rd_prv, rd_head, rd_tail, rd_cnt;
  logic [TIME_W-1:0] rd_exp;
  logic [CW-1:0]     rd_cls;
  logic              rd_lnk;

  // working registers
  kind_t             kind_q;
  logic              e_valid;
  logic [TIME_W-1:0] exp_q, now_q;
  logic [PW-1:0]     cur, cur_next;
  logic [CW-1:0]     csel, csel_next;
  logic [PW-1:0]     h, h_next;
  logic [PW-1:0]     tail_q;
  logic [PW-1:0]     cnt, cnt_next;
  logic [NW-1:0]     scan_n;
  logic              expired;
  logic [RW-1:0]     clr;

  logic [AW-1:0] naddr;
  logic          p_null, n_null, h_null, hit, stop;
  logic          clr_ent, clr_cls;

  assign p_null  = (rd_prv >= NIL);
  assign n_null  = (rd_nxt >= NIL);
  assign h_null  = (h >= NIL);
  assign hit     = (rd_exp != '0) && (rd_exp < now_q);
  assign stop    = (scan_n == NW'(SCAN_DEPTH - 1)) || p_null;
  assign clr_ent = cmd.clr && (32'(clr) < 32'(NUM_ENTRIES));
  assign clr_cls = cmd.clr && (32'(clr) < 32'(NUM_CLASSES));

  always_comb begin
    cur_next = cur;
    if (cmd.load) begin
      cur_next = PW'(entry);
    end else if (cmd.cap_tail) begin
      cur_next = rd_tail;
    end else if (cmd.scan && !hit) begin
      cur_next = stop ? tail_q : rd_prv;
    end
  end

  always_comb begin
    csel_next = csel;
    if (cmd.load) begin
      csel_next = cmod_tab[list_class];
    end else if (cmd.cap_cls) begin
      csel_next = rd_cls;
    end
  end

  always_comb begin
    h_next = h;
    if (cmd.cap_head) begin
      h_next = rd_head;
    end else if (cmd.unlink) begin
      h_next = p_null ? rd_nxt : rd_head;
    end
  end

  always_comb begin
    cnt_next = cnt;
    if (cmd.cap_cnt) begin
      cnt_next = rd_cnt;
    end else if (cmd.unlink) begin
      cnt_next = cnt - PW'(cnt != '0);
    end else if (cmd.link) begin
      cnt_next = cnt + PW'(1);
    end
  end

  assign naddr = AW'(cur_next);

  always_ff @(posedge clk) begin
    cur  <= cur_next;
    csel <= csel_next;
    h    <= h_next;
    cnt  <= cnt_next;
    if (cmd.load) begin
      kind_q  <= kind_t'(kind);
      e_valid <= (32'(entry) < 32'(NUM_ENTRIES));
      exp_q   <= expiry;
      now_q   <= now;
    end
    if (cmd.cap_tail) begin
      tail_q <= rd_tail;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      scan_n  <= '0;
      expired <= 1'b0;
    end else if (cmd.scan) begin
      if (hit) begin
        expired <= 1'b1;
      end else if (!stop) begin
        scan_n <= scan_n + NW'(1);
      end
    end
  end

  // clearing pass counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr <= '0;
    end else if (cmd.clr) begin
      clr <= clr + RW'(1);
    end
  end

  // entry tables
  always_ff @(posedge clk) begin
    if (cmd.unlink && !p_null) begin
      nxt_mem[AW'(rd_prv)] <= rd_nxt;
    end else if (cmd.link) begin
      nxt_mem[AW'(cur)] <= h;
    end
    rd_nxt <= nxt_mem[naddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.unlink && !n_null) begin
      prv_mem[AW'(rd_nxt)] <= rd_prv;
    end else if (cmd.link) begin
      prv_mem[AW'(cur)] <= NIL;
    end else if (cmd.link2 && !h_null) begin
      prv_mem[AW'(h)] <= cur;
    end
    rd_prv <= prv_mem[naddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.link && (kind_q == KIND_ADD)) begin
      exp_mem[AW'(cur)] <= exp_q;
    end
    rd_exp <= exp_mem[naddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.link) begin
      cls_mem[AW'(cur)] <= csel;
    end
    rd_cls <= cls_mem[naddr];
  end

  always_ff @(posedge clk) begin
    if (clr_ent) begin
      lnk_mem[AW'(clr)] <= 1'b0;
    end else if (cmd.unlink) begin
      lnk_mem[AW'(cur)] <= 1'b0;
    end else if (cmd.link) begin
      lnk_mem[AW'(cur)] <= 1'b1;
    end
    rd_lnk <= lnk_mem[naddr];
  end

  // class tables
  always_ff @(posedge clk) begin
    if (clr_cls) begin
      head_mem[CW'(clr)] <= NIL;
    end else if (cmd.unlink && p_null) begin
      head_mem[csel] <= rd_nxt;
    end else if (cmd.link) begin
      head_mem[csel] <= cur;
    end
    rd_head <= head_mem[csel_next];
  end

  always_ff @(posedge clk) begin
    if (clr_cls) begin
      tail_mem[CW'(clr)] <= NIL;
    end else if (cmd.unlink && n_null) begin
      tail_mem[csel] <= rd_prv;
    end else if (cmd.link && h_null) begin
      tail_mem[csel] <= cur;
    end
    rd_tail <= tail_mem[csel_next];
  end

  always_ff @(posedge clk) begin
    if (clr_cls) begin
      cnt_mem[CW'(clr)] <= '0;
    end else if (cmd.unlink || cmd.link) begin
      cnt_mem[csel] <= cnt_next;
    end
    rd_cnt <= cnt_mem[csel_next];
  end

  // result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      status <= cmd.fin_status;
      if (cmd.fin_status == ST_OK) begin
        victim_entry   <= (kind_q == KIND_RECYCLE) ? ENTRY_W'(cur) : '0;
        victim_expired <= (kind_q == KIND_RECYCLE) && expired;
        list_count     <= COUNT_W'(cnt_next);
      end else begin
        victim_entry   <= '0;
        victim_expired <= 1'b0;
        list_count     <= '0;
      end
    end
  end

  assign stat.kind      = kind_q;
  assign stat.e_valid   = e_valid;
  assign stat.linked    = e_valid && rd_lnk;
  assign stat.tail_null = (rd_tail >= NIL);
  assign stat.scan_hit  = hit;
  assign stat.scan_stop = stop;
  assign stat.clr_done  = (clr == RW'(CLR_N - 1));

endmodule

`default_nettype wire

// ===== hw/rtl/mlre_ctrl.sv =====
// ----------------------------------------------------------------------------
// mlre_ctrl
// Sequencer: clearing pass, lookup, tail scan, unlink and head link steps.
// ----------------------------------------------------------------------------
`default_nettype none

module mlre_ctrl import mlre_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire mlre_stat_t stat,
  output mlre_cmd_t       cmd
);

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_RD1    = 8'b0000_0100,
    S_RD2    = 8'b0000_1000,
    S_SCAN   = 8'b0001_0000,
    S_UNLINK = 8'b0010_0000,
    S_LINK   = 8'b0100_0000,
    S_LINK2  = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.fin_status = ST_OK;
    unique case (state)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (stat.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_RD1;
        end
      end
      S_RD1: begin
        unique case (stat.kind)
          KIND_ADD: begin
            if (!stat.e_valid || stat.linked) begin
              cmd.finish     = 1'b1;
              cmd.fin_status = stat.e_valid ? ST_LINKED : ST_UNLINKED;
              state_next     = S_IDLE;
            end else begin
              cmd.cap_head = 1'b1;
              cmd.cap_cnt  = 1'b1;
              state_next   = S_LINK;
            end
          end
          KIND_REMOVE, KIND_ACCESS: begin
            if (!stat.linked) begin
              cmd.finish     = 1'b1;
              cmd.fin_status = ST_UNLINKED;
              state_next     = S_IDLE;
            end else begin
              cmd.cap_cls = 1'b1;
              state_next  = S_RD2;
            end
          end
          KIND_RECYCLE: begin
            if (stat.tail_null) begin
              cmd.finish     = 1'b1;
              cmd.fin_status = ST_EMPTY;
              state_next     = S_IDLE;
            end else begin
              cmd.cap_cnt  = 1'b1;
              cmd.cap_tail = 1'b1;
              state_next   = S_SCAN;
            end
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_RD2: begin
        cmd.cap_cnt = 1'b1;
        state_next  = S_UNLINK;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_hit || stat.scan_stop) state_next = S_UNLINK;
      end
      S_UNLINK: begin
        cmd.unlink = 1'b1;
        if (stat.kind == KIND_ACCESS) begin
          state_next = S_LINK;
        end else begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_LINK: begin
        cmd.link   = 1'b1;
        state_next = S_LINK2;
      end
      S_LINK2: begin
        cmd.link2  = 1'b1;
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mlre_checker.sv =====
// ----------------------------------------------------------------------------
// mlre_checker
// Port-level checks for the segmented LRU list block.
// ----------------------------------------------------------------------------
`default_nettype none

`include "multi_list_lru_with_expiry_recycle_top_assert.svh"

module mlre_checker import mlre_pkg::*; (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                start,
  input wire logic                busy,
  input wire logic                done,
  input wire logic [1:0]          status,
  input wire logic [ENTRY_W-1:0]  victim_entry,
  input wire logic                victim_expired,
  input wire logic [COUNT_W-1:0]  list_count
);

  `MLRE_ASSERT_NEXT(a_start_busy, clk, rst, start && !busy, busy, "no busy after accept")
  `MLRE_ASSERT_SAME(a_done_idle, clk, rst, done, !busy, "result while busy")
  `MLRE_ASSERT_NEXT(a_done_single, clk, rst, done, !done, "result repeated")
  `MLRE_ASSERT_SAME(a_err_zero, clk, rst, done && (status != ST_OK), (victim_entry == '0) && !victim_expired && (list_count == '0), "error result not zeroed")

endmodule

bind multi_list_lru_with_expiry_recycle_top mlre_checker u_mlre_checker (.*);

`default_nettype wire
